@@ rtl/core/rbe_pkg.sv @@
`default_nettype none
package rbe_pkg;

  typedef logic signed [31:0] q_t;
  typedef logic [2:0][31:0] vec_t;

  // one body row as held in the state memory
  typedef struct packed {
    vec_t pos;
    vec_t vel;
    vec_t mom;
    vec_t ori;
    vec_t am;
    vec_t av;
    vec_t frc;
    vec_t trq;
    logic [31:0] im;
  } row_t;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_FORCE    = 3'd1,
    OP_IMP_CTR  = 3'd2,
    OP_IMP_PT   = 3'd3,
    OP_TORQUE   = 3'd4,
    OP_UPDATE   = 3'd5
  } op_e;

  typedef struct packed {
    vec_t        vec;
    vec_t        pt;
    logic [30:0] mass;
    logic [30:0] imass;
    logic [2:0]  op;
  } item_t;

  typedef struct packed {
    logic        load;
    logic [3:0]  step;
    logic [30:0] dt;
  } exec_ctrl_t;

  localparam logic [30:0] TimeStepReset = 31'd65536;
  localparam int unsigned RegTimeStep = 0;

  function automatic q_t sat33(input logic signed [32:0] v);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = 33'sh0_7fff_ffff;
    lo = -33'sh0_8000_0000;
    if (v > hi) return 32'sh7fff_ffff;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // shift right by 16 (floor) and saturate
  function automatic q_t qfin(input logic signed [65:0] p);
    logic signed [65:0] s;
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    s  = p >>> 16;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (s > hi) return 32'sh7fff_ffff;
    else if (s < lo) return 32'sh8000_0000;
    else return s[31:0];
  endfunction

  function automatic logic signed [32:0] sx(input logic [31:0] a);
    return {a[31], a};
  endfunction

  function automatic logic signed [32:0] ux(input logic [30:0] a);
    return {2'b00, a};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/rbe_ram.sv @@
`default_nettype none
module rbe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/rbe_exec.sv @@
`default_nettype none
module rbe_exec (
  input  wire logic               clk_i,
  input  wire rbe_pkg::exec_ctrl_t ctrl_i,
  input  wire rbe_pkg::item_t      item_i,
  input  wire rbe_pkg::row_t       rd_row_i,
  output rbe_pkg::row_t            row_d_o,
  output logic                     last_o
);

  rbe_pkg::row_t w_q, w_d;
  rbe_pkg::vec_t rel_q, rel_d, t1_q, t1_d;
  logic signed [32:0] ma [3];
  logic signed [32:0] mb [3];
  logic signed [65:0] pr_q [3];
  rbe_pkg::q_t        pf [3];
  rbe_pkg::op_e       op;

  assign op = rbe_pkg::op_e'(item_i.op);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pf[i] = rbe_pkg::qfin(pr_q[i]);
    end
  end

  always_comb begin
    int nx;
    int pv;
    w_d    = w_q;
    rel_d  = rel_q;
    t1_d   = t1_q;
    last_o = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      nx = (i == 2) ? 0 : i + 1;
      pv = (i == 0) ? 2 : i - 1;
      unique case (op)
        rbe_pkg::OP_LOAD: begin
          unique case (ctrl_i.step)
            4'd0: begin
              ma[i] = rbe_pkg::sx(item_i.vec[i]);
              mb[i] = rbe_pkg::ux(item_i.mass);
            end
            default: begin
              w_d.mom[i] = pf[i];
              w_d.pos[i] = item_i.pt[i];
              w_d.vel[i] = item_i.vec[i];
              w_d.ori[i] = '0;
              w_d.am[i]  = '0;
              w_d.av[i]  = '0;
              w_d.frc[i] = '0;
              w_d.trq[i] = '0;
              w_d.im     = {1'b0, item_i.imass};
              last_o     = 1'b1;
            end
          endcase
        end
        rbe_pkg::OP_FORCE: begin
          unique case (ctrl_i.step)
            4'd0: begin
              w_d.frc[i] = rbe_pkg::qadd(w_q.frc[i], item_i.vec[i]);
              rel_d[i]   = rbe_pkg::qsub(item_i.pt[i], w_q.pos[i]);
            end
            4'd1: begin
              ma[i] = rbe_pkg::sx(rel_q[nx]);
              mb[i] = rbe_pkg::sx(item_i.vec[pv]);
            end
            4'd2: begin
              t1_d[i] = pf[i];
              ma[i]   = rbe_pkg::sx(rel_q[pv]);
              mb[i]   = rbe_pkg::sx(item_i.vec[nx]);
            end
            default: begin
              w_d.trq[i] = rbe_pkg::qadd(w_q.trq[i], rbe_pkg::qsub(t1_q[i], pf[i]));
              last_o     = 1'b1;
            end
          endcase
        end
        rbe_pkg::OP_IMP_CTR: begin
          unique case (ctrl_i.step)
            4'd0: w_d.mom[i] = rbe_pkg::qadd(w_q.mom[i], item_i.vec[i]);
            4'd1: begin
              ma[i] = rbe_pkg::sx(w_q.im);
              mb[i] = rbe_pkg::sx(w_q.mom[i]);
            end
            default: begin
              w_d.vel[i] = pf[i];
              last_o     = 1'b1;
            end
          endcase
        end
        rbe_pkg::OP_IMP_PT: begin
          unique case (ctrl_i.step)
            4'd0: begin
              w_d.mom[i] = rbe_pkg::qadd(w_q.mom[i], item_i.vec[i]);
              rel_d[i]   = rbe_pkg::qsub(item_i.pt[i], w_q.pos[i]);
            end
            4'd1: begin
              ma[i] = rbe_pkg::sx(w_q.im);
              mb[i] = rbe_pkg::sx(w_q.mom[i]);
            end
            4'd2: begin
              w_d.vel[i] = pf[i];
              ma[i]      = rbe_pkg::sx(rel_q[nx]);
              mb[i]      = rbe_pkg::sx(item_i.vec[pv]);
            end
            4'd3: begin
              t1_d[i] = pf[i];
              ma[i]   = rbe_pkg::sx(rel_q[pv]);
              mb[i]   = rbe_pkg::sx(item_i.vec[nx]);
            end
            4'd4: w_d.am[i] = rbe_pkg::qadd(w_q.am[i], rbe_pkg::qsub(t1_q[i], pf[i]));
            4'd5: begin
              ma[i] = rbe_pkg::sx(w_q.im);
              mb[i] = rbe_pkg::sx(w_q.am[i]);
            end
            default: begin
              w_d.av[i] = pf[i];
              last_o    = 1'b1;
            end
          endcase
        end
        rbe_pkg::OP_TORQUE: begin
          unique case (ctrl_i.step)
            4'd0: w_d.am[i] = rbe_pkg::qadd(w_q.am[i], item_i.vec[i]);
            4'd1: begin
              ma[i] = rbe_pkg::sx(w_q.im);
              mb[i] = rbe_pkg::sx(w_q.am[i]);
            end
            default: begin
              w_d.av[i] = pf[i];
              last_o    = 1'b1;
            end
          endcase
        end
        rbe_pkg::OP_UPDATE: begin
          unique case (ctrl_i.step)
            4'd0: begin
              ma[i] = rbe_pkg::sx(w_q.frc[i]);
              mb[i] = rbe_pkg::ux(ctrl_i.dt);
            end
            4'd1: w_d.mom[i] = rbe_pkg::qadd(w_q.mom[i], pf[i]);
            4'd2: begin
              ma[i] = rbe_pkg::sx(w_q.im);
              mb[i] = rbe_pkg::sx(w_q.mom[i]);
            end
            4'd3: w_d.vel[i] = pf[i];
            4'd4: begin
              ma[i] = rbe_pkg::sx(w_q.vel[i]);
              mb[i] = rbe_pkg::ux(ctrl_i.dt);
            end
            4'd5: w_d.pos[i] = rbe_pkg::qadd(w_q.pos[i], pf[i]);
            4'd6: begin
              ma[i] = rbe_pkg::sx(w_q.trq[i]);
              mb[i] = rbe_pkg::ux(ctrl_i.dt);
            end
            4'd7: w_d.am[i] = rbe_pkg::qadd(w_q.am[i], pf[i]);
            4'd8: begin
              ma[i] = rbe_pkg::sx(w_q.im);
              mb[i] = rbe_pkg::sx(w_q.am[i]);
            end
            4'd9: w_d.av[i] = pf[i];
            4'd10: begin
              ma[i] = rbe_pkg::sx(w_q.av[i]);
              mb[i] = rbe_pkg::ux(ctrl_i.dt);
            end
            default: begin
              w_d.ori[i] = rbe_pkg::qadd(w_q.ori[i], pf[i]);
              w_d.frc[i] = '0;
              w_d.trq[i] = '0;
              last_o     = 1'b1;
            end
          endcase
        end
        default: last_o = 1'b1;
      endcase
    end
  end

  assign row_d_o = w_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      w_q <= rd_row_i;
    end else begin
      w_q <= w_d;
    end
    rel_q <= rel_d;
    t1_q  <= t1_d;
    for (int i = 0; i < 3; i++) begin
      pr_q[i] <= ma[i] * mb[i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rigid_body_euler_integrator.sv @@
`default_nettype none
// channel      direction  handshake                      payload
// item         in         start high while busy low      op, body, vec_*, point_*, mass, inv mass
// result       out        done_o strobe, one cycle       pos_*, vel_*, spin_*, turn_*
// config       in         apb write, psel&penable&pwrite time_step at byte address 0
//
// one item takes a memory read state and then the execute steps of its op (load, force,
// centre impulse, point impulse, torque, update); the update
// runs six multiplies per axis in sequence through three multiplier lanes; unused op
// codes end at the first execute step
// after reset a clearing pass writes zero to every body row with busy high;
// configuration writes are taken during it
// the result is registered and strobed for one cycle; a new item can be accepted
// in the cycle the strobe is shown
module rigid_body_euler_integrator #(
  parameter int NUM_BODIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item transaction
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  op_i,
  input  wire logic [3:0]  body_i,
  input  wire logic [31:0] vec_x_i,
  input  wire logic [31:0] vec_y_i,
  input  wire logic [31:0] vec_z_i,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] point_z_i,
  input  wire logic [30:0] mass_i,
  input  wire logic [30:0] inverse_mass_i,
  // result transaction
  output logic             done_o,
  output logic [31:0]      pos_x_o,
  output logic [31:0]      pos_y_o,
  output logic [31:0]      pos_z_o,
  output logic [31:0]      vel_x_o,
  output logic [31:0]      vel_y_o,
  output logic [31:0]      vel_z_o,
  output logic [31:0]      spin_x_o,
  output logic [31:0]      spin_y_o,
  output logic [31:0]      spin_z_o,
  output logic [31:0]      turn_x_o,
  output logic [31:0]      turn_y_o,
  output logic [31:0]      turn_z_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AddrW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
  localparam int RowW  = $bits(rbe_pkg::row_t);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [3:0]       step_q, step_d;
  logic [30:0]      dt_q;
  logic             done_q, done_d;
  rbe_pkg::item_t   item_q, item_d;
  rbe_pkg::row_t    out_q, out_d;

  logic             accept;
  logic             in_range;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [RowW-1:0]  wdata;
  logic [RowW-1:0]  rdata;
  rbe_pkg::row_t    row_d;
  logic             last;
  rbe_pkg::exec_ctrl_t ctrl;
  logic             reg_sel;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(body_i) < NUM_BODIES);
  assign raddr    = AddrW'(body_i);

  // configuration: a single register, time step
  assign pready  = 1'b1;
  assign reg_sel = (32'(paddr[2]) == rbe_pkg::RegTimeStep);
  assign prdata  = reg_sel ? {1'b0, dt_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= rbe_pkg::TimeStepReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      dt_q <= pwdata[30:0];
    end
  end

  assign ctrl.load = (state_q == S_READ);
  assign ctrl.step = step_q;
  assign ctrl.dt   = dt_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    idx_d   = idx_q;
    step_d  = step_q;
    item_d  = item_q;
    out_d   = out_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = row_d;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(NUM_BODIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_range) begin
            // latch the item and fetch the body row
            idx_d       = raddr;
            item_d.op   = op_i;
            item_d.vec  = {vec_z_i, vec_y_i, vec_x_i};
            item_d.pt   = {point_z_i, point_y_i, point_x_i};
            item_d.mass = mass_i;
            item_d.imass = inverse_mass_i;
            state_d     = S_READ;
          end else begin
            // body beyond the table: nothing changes, all-zero result
            out_d  = '0;
            done_d = 1'b1;
          end
        end
      end
      S_READ: begin
        step_d  = '0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (last) begin
          we      = 1'b1;
          out_d   = row_d;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  rbe_ram #(
    .Width(RowW),
    .Depth(NUM_BODIES),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  rbe_exec u_exec (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .item_i  (item_q),
    .rd_row_i(rbe_pkg::row_t'(rdata)),
    .row_d_o (row_d),
    .last_o  (last)
  );

  assign done_o   = done_q;
  assign pos_x_o  = out_q.pos[0];
  assign pos_y_o  = out_q.pos[1];
  assign pos_z_o  = out_q.pos[2];
  assign vel_x_o  = out_q.vel[0];
  assign vel_y_o  = out_q.vel[1];
  assign vel_z_o  = out_q.vel[2];
  assign spin_x_o = out_q.av[0];
  assign spin_y_o = out_q.av[1];
  assign spin_z_o = out_q.av[2];
  assign turn_x_o = out_q.ori[0];
  assign turn_y_o = out_q.ori[1];
  assign turn_z_o = out_q.ori[2];

endmodule
`default_nettype wire
